// File: src/playfair_cipher_encoder_core_assert.svh
// Assertion macros used by the checker file of the Playfair encoder.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef PLAYFAIR_CIPHER_ENCODER_CORE_ASSERT_SVH
`define PLAYFAIR_CIPHER_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PFE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define PFE_ASSERT_RST(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: src/pfe_pkg.sv
// Types, constants and small coordinate helpers of the Playfair encoder.
// Depends on nothing; used by the interfaces and the top level.
`default_nettype none

package pfe_pkg;

   localparam int NumLetters = 26;
   localparam int Side       = 5;
   localparam int Cells      = 25;
   localparam int SideLast   = 4;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;

   localparam letter_type LetterV = 5'd21;
   localparam letter_type LetterW = 5'd22;
   localparam letter_type LetterX = 5'd23;

   typedef enum logic [1:0] {
      ACT_KEY    = 2'd0,
      ACT_FINISH = 2'd1,
      ACT_TEXT   = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   function automatic coord_type cell_row(cell_type p);
      coord_type r;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic cell_type cell_index(coord_type r, coord_type c);
      return 5'(5'(r) * 5'(Side) + 5'(c));
   endfunction

   function automatic coord_type cell_col(cell_type p);
      cell_type base;
      base = cell_index(cell_row(p), 3'd0);
      return 3'(p - base);
   endfunction

   function automatic coord_type step_coord(coord_type x);
      return (x == 3'(SideLast)) ? 3'd0 : 3'(x + 3'd1);
   endfunction

endpackage

`default_nettype wire

// File: src/pfe_req_if.sv
// Input channel of the Playfair encoder: valid, ready and one action item.
// Depends on pfe_pkg for the field types.
`default_nettype none

interface pfe_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   pfe_pkg::letter_type letter;

   modport source (output valid, output action, output letter, input ready);
   modport sink   (input valid, input action, input letter, output ready);
endinterface

`default_nettype wire

// File: src/pfe_rsp_if.sv
// Result channel of the Playfair encoder: valid, ready, one cipher letter and last.
// Depends on pfe_pkg for the field types.
`default_nettype none

interface pfe_rsp_if;
   logic                valid;
   logic                ready;
   pfe_pkg::letter_type cipher_letter;
   logic                last;

   modport source (output valid, output cipher_letter, output last, input ready);
   modport sink   (input valid, input cipher_letter, input last, output ready);
endinterface

`default_nettype wire

// File: src/playfair_cipher_encoder_core.sv
// Playfair encoder top level: key loading, square fill and pair encoding.
// Depends on pfe_pkg, pfe_req_if, pfe_rsp_if and pfe_ram.
//
// Items arrive on req_ch (action, letter) and cipher letters leave on rsp_ch;
// each transfer happens when valid and ready are both high. A finish-key item
// walks the alphabet once, one letter a cycle, so req_ch.ready stays low
// until the walk is done. A text letter that closes a pair, or an end of text
// that pads an open pair with X, passes through PLA, PLB, PLC, SQ1, WR1, SQ2
// and WR2: two reads of the letter-place memory and two reads of the square
// memory, each through its single registered read port. The first cipher
// letter is loaded into the result register in WR1 and the second, marked
// by last, in WR2. One result register sits on rsp_ch; while the receiver
// holds ready low, the sequencer in WR1 or WR2 waits there with that register
// full and req_ch.ready low. Synchronous reset clears the letter-used flags,
// the fill count, the key and pair status and the result register; the
// memories are not cleared.
`default_nettype none

module playfair_cipher_encoder_core (
   input  wire logic clock,
   input  wire logic reset,
   pfe_req_if.sink   req_ch,
   pfe_rsp_if.source rsp_ch
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_FILL = 9'b000000010,
      ST_PLA  = 9'b000000100,
      ST_PLB  = 9'b000001000,
      ST_PLC  = 9'b000010000,
      ST_SQ1  = 9'b000100000,
      ST_WR1  = 9'b001000000,
      ST_SQ2  = 9'b010000000,
      ST_WR2  = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [25:0]         used_ff, used_in;
   logic [4:0]          fill_ff, fill_in;
   logic                key_done_ff, key_done_in;
   pfe_pkg::letter_type pend_letter_ff, pend_letter_in;
   logic                pend_valid_ff, pend_valid_in;
   pfe_pkg::letter_type second_ff, second_in;
   pfe_pkg::letter_type scan_ff, scan_in;
   pfe_pkg::cell_type   pa_ff, pa_in;
   pfe_pkg::cell_type   addr1_ff, addr1_in;
   pfe_pkg::cell_type   addr2_ff, addr2_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pfe_pkg::letter_type rsp_letter_ff, rsp_letter_in;
   logic                rsp_last_ff, rsp_last_in;

   pfe_pkg::letter_type in_letter;
   logic                req_xfer;
   logic                in_range;
   logic                place_req;
   logic                place_en;
   pfe_pkg::letter_type place_letter;
   logic                slot_free;
   pfe_pkg::letter_type lp_rd_addr;
   pfe_pkg::cell_type   lp_rd_data;
   pfe_pkg::cell_type   sq_rd_addr;
   pfe_pkg::letter_type sq_rd_data;
   pfe_pkg::coord_type  r1, c1, r2, c2;

   assign in_letter = (req_ch.letter == pfe_pkg::LetterW) ? pfe_pkg::LetterV : req_ch.letter;
   assign in_range  = (in_letter < 5'(pfe_pkg::NumLetters));
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign place_letter = (state_ff == ST_FILL) ? scan_ff : in_letter;
   assign place_req = (req_xfer && (req_ch.action == pfe_pkg::ACT_KEY) && !key_done_ff
                       && in_range)
                   || ((state_ff == ST_FILL) && (scan_ff != pfe_pkg::LetterW));
   assign place_en  = place_req && !used_ff[place_letter] && (fill_ff < 5'(pfe_pkg::Cells));

   assign lp_rd_addr = (state_ff == ST_PLA) ? pend_letter_ff : second_ff;
   assign sq_rd_addr = ((state_ff == ST_SQ1) || (state_ff == ST_WR1)) ? addr1_ff : addr2_ff;

   assign r1 = pfe_pkg::cell_row(pa_ff);
   assign c1 = pfe_pkg::cell_col(pa_ff);
   assign r2 = pfe_pkg::cell_row(lp_rd_data);
   assign c2 = pfe_pkg::cell_col(lp_rd_data);

   pfe_ram #(
      .Width (5),
      .Depth (pfe_pkg::Cells)
   ) u_square_ram (
      .clock   (clock),
      .wr_en   (place_en),
      .wr_addr (fill_ff),
      .wr_data (place_letter),
      .rd_addr (sq_rd_addr),
      .rd_data (sq_rd_data)
   );

   pfe_ram #(
      .Width (5),
      .Depth (pfe_pkg::NumLetters)
   ) u_place_ram (
      .clock   (clock),
      .wr_en   (place_en),
      .wr_addr (place_letter),
      .wr_data (fill_ff),
      .rd_addr (lp_rd_addr),
      .rd_data (lp_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      fill_in        = fill_ff;
      key_done_in    = key_done_ff;
      pend_letter_in = pend_letter_ff;
      pend_valid_in  = pend_valid_ff;
      second_in      = second_ff;
      scan_in        = scan_ff;
      pa_in          = pa_ff;
      addr1_in       = addr1_ff;
      addr2_in       = addr2_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_letter_in  = rsp_letter_ff;
      rsp_last_in    = rsp_last_ff;

      if (place_en) begin
         used_in[place_letter] = 1'b1;
         fill_in = 5'(fill_ff + 5'd1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_ch.action)
                  pfe_pkg::ACT_FINISH: begin
                     if (!key_done_ff) begin
                        scan_in  = '0;
                        state_in = ST_FILL;
                     end
                  end
                  pfe_pkg::ACT_TEXT: begin
                     if (key_done_ff && in_range) begin
                        if (!pend_valid_ff) begin
                           pend_letter_in = in_letter;
                           pend_valid_in  = 1'b1;
                        end else begin
                           second_in     = in_letter;
                           pend_valid_in = 1'b0;
                           state_in      = ST_PLA;
                        end
                     end
                  end
                  pfe_pkg::ACT_END: begin
                     if (key_done_ff && pend_valid_ff) begin
                        second_in     = pfe_pkg::LetterX;
                        pend_valid_in = 1'b0;
                        state_in      = ST_PLA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            scan_in = 5'(scan_ff + 5'd1);
            if (scan_ff == 5'(pfe_pkg::NumLetters - 1)) begin
               key_done_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_PLA: begin
            state_in = ST_PLB;
         end
         ST_PLB: begin
            pa_in    = lp_rd_data;
            state_in = ST_PLC;
         end
         ST_PLC: begin
            if (r1 == r2) begin
               addr1_in = pfe_pkg::cell_index(r1, pfe_pkg::step_coord(c1));
               addr2_in = pfe_pkg::cell_index(r2, pfe_pkg::step_coord(c2));
            end else if (c1 == c2) begin
               addr1_in = pfe_pkg::cell_index(pfe_pkg::step_coord(r1), c1);
               addr2_in = pfe_pkg::cell_index(pfe_pkg::step_coord(r2), c2);
            end else begin
               addr1_in = pfe_pkg::cell_index(r1, c2);
               addr2_in = pfe_pkg::cell_index(r2, c1);
            end
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            state_in = ST_WR1;
         end
         ST_WR1: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_letter_in = sq_rd_data;
               rsp_last_in   = 1'b0;
               state_in      = ST_SQ2;
            end
         end
         ST_SQ2: begin
            state_in = ST_WR2;
         end
         ST_WR2: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_letter_in = sq_rd_data;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         fill_ff       <= '0;
         key_done_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         key_done_ff   <= key_done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_letter_ff <= pend_letter_in;
      second_ff      <= second_in;
      scan_ff        <= scan_in;
      pa_ff          <= pa_in;
      addr1_ff       <= addr1_in;
      addr2_ff       <= addr2_in;
      rsp_letter_ff  <= rsp_letter_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cipher_letter = rsp_letter_ff;
   assign rsp_ch.last          = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/pfe_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Standalone; instantiated by the Playfair encoder top level.
`default_nettype none

module pfe_ram #(
   parameter int Width = 5,
   parameter int Depth = 25
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/pfe_checker.sv
// Port-level checker for the Playfair encoder, bound to the top level.
// Depends on playfair_cipher_encoder_core_assert.svh for the assertion macros.
`default_nettype none

`include "playfair_cipher_encoder_core_assert.svh"

module pfe_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last
);

   logic expect_second_ff, expect_second_in;

   always_comb begin
      expect_second_in = expect_second_ff;
      if (rsp_valid && rsp_ready) begin
         expect_second_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_second_ff <= 1'b0;
      end else begin
         expect_second_ff <= expect_second_in;
      end
   end

   `PFE_ASSERT_RST(a_rsp_idle_after_reset, !rsp_valid, "result valid right after reset")
   `PFE_ASSERT_NXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "stalled result dropped")
   `PFE_ASSERT_IMP(a_busy_during_pair, rsp_valid && !rsp_last, !req_ready, "ready during a pair")
   `PFE_ASSERT_IMP(a_pair_order, rsp_valid && rsp_ready, rsp_last == expect_second_ff, "pair order broken")

endmodule

bind playfair_cipher_encoder_core pfe_checker u_pfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.last)
);

`default_nettype wire

// File: test/tb.sv
// Testbench of playfair_cipher_encoder_core: random key, text and noise transfers.
// Results are checked against a predictor of the key square and pair encoding.
// Depends on pfe_pkg, pfe_req_if, pfe_rsp_if and the encoder RTL.
`timescale 1ns / 100ps

module tb;

   typedef struct {
      pfe_pkg::action_type act;
      pfe_pkg::letter_type letter;
   } plain_item_type;

   typedef struct {
      pfe_pkg::letter_type cipher_letter;
      logic                last;
   } cipher_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfe_req_if req_ch ();
   pfe_rsp_if rsp_ch ();

   playfair_cipher_encoder_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   plain_item_type  plain_backlog[$];
   cipher_item_type cipher_due[$];
   plain_item_type  next_plain;
   int              error_count = 0;
   int              send_gap = 0;
   int              hold_left = 0;
   bit              steady = 1'b0;
   int              steady_left = 0;

   pfe_pkg::letter_type key_square[pfe_pkg::Cells];
   pfe_pkg::cell_type   letter_cell[pfe_pkg::NumLetters];
   bit                  letter_placed[pfe_pkg::NumLetters] = '{default: 1'b0};
   int                  cells_filled = 0;
   bit                  square_done = 1'b0;
   bit                  pair_open = 1'b0;
   pfe_pkg::letter_type open_letter = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   task automatic place_key_letter(input pfe_pkg::letter_type l);
      if (!letter_placed[l] && cells_filled < pfe_pkg::Cells) begin
         key_square[cells_filled] = l;
         letter_cell[l] = 5'(cells_filled);
         letter_placed[l] = 1'b1;
         cells_filled++;
      end
   endtask

   task automatic add_cipher(input pfe_pkg::letter_type l, input logic is_last);
      cipher_item_type item;
      item.cipher_letter = l;
      item.last = is_last;
      cipher_due.insert(cipher_due.size(), item);
   endtask

   task automatic encode_pair(input pfe_pkg::letter_type a, input pfe_pkg::letter_type b);
      int r1, c1, r2, c2;
      pfe_pkg::letter_type o1, o2;
      r1 = int'(letter_cell[a]) / pfe_pkg::Side;
      c1 = int'(letter_cell[a]) % pfe_pkg::Side;
      r2 = int'(letter_cell[b]) / pfe_pkg::Side;
      c2 = int'(letter_cell[b]) % pfe_pkg::Side;
      if (r1 == r2) begin
         o1 = key_square[r1 * pfe_pkg::Side + (c1 + 1) % pfe_pkg::Side];
         o2 = key_square[r2 * pfe_pkg::Side + (c2 + 1) % pfe_pkg::Side];
      end else if (c1 == c2) begin
         o1 = key_square[((r1 + 1) % pfe_pkg::Side) * pfe_pkg::Side + c1];
         o2 = key_square[((r2 + 1) % pfe_pkg::Side) * pfe_pkg::Side + c2];
      end else begin
         o1 = key_square[r1 * pfe_pkg::Side + c2];
         o2 = key_square[r2 * pfe_pkg::Side + c1];
      end
      add_cipher(o1, 1'b0);
      add_cipher(o2, 1'b1);
   endtask

   task automatic apply_plain(input pfe_pkg::action_type act, input pfe_pkg::letter_type raw);
      pfe_pkg::letter_type l;
      int k;
      l = (raw == pfe_pkg::LetterW) ? pfe_pkg::LetterV : raw;
      case (act)
         pfe_pkg::ACT_KEY: begin
            if (!square_done && l < pfe_pkg::NumLetters) place_key_letter(l);
         end
         pfe_pkg::ACT_FINISH: begin
            if (!square_done) begin
               for (k = 0; k < pfe_pkg::NumLetters; k++) begin
                  if (5'(k) != pfe_pkg::LetterW) place_key_letter(5'(k));
               end
               square_done = 1'b1;
            end
         end
         pfe_pkg::ACT_TEXT: begin
            if (square_done && l < pfe_pkg::NumLetters) begin
               if (!pair_open) begin
                  open_letter = l;
                  pair_open = 1'b1;
               end else begin
                  encode_pair(open_letter, l);
                  pair_open = 1'b0;
               end
            end
         end
         pfe_pkg::ACT_END: begin
            if (square_done && pair_open) begin
               encode_pair(open_letter, pfe_pkg::LetterX);
               pair_open = 1'b0;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_cipher(input pfe_pkg::letter_type got_letter, input logic got_last);
      cipher_item_type want;
      if (cipher_due.size() == 0) begin
         report_mismatch($sformatf("cipher letter %0d with no result pending", got_letter));
      end else begin
         want = cipher_due.pop_front();
         if (got_letter !== want.cipher_letter) begin
            report_mismatch($sformatf("cipher_letter %0d, predicted %0d",
                                      got_letter, want.cipher_letter));
         end
         if (got_last !== want.last) begin
            report_mismatch($sformatf("last %b, predicted %b", got_last, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (steady_left == 0) begin
         steady <= ($urandom_range(0, 3) == 0);
         steady_left <= $urandom_range(40, 300);
      end else begin
         steady_left <= steady_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_plain(pfe_pkg::action_type'(req_ch.action), req_ch.letter);
            send_gap = draw_gap();
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (plain_backlog.size() != 0) begin
               next_plain = plain_backlog.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.action <= next_plain.act;
               req_ch.letter <= next_plain.letter;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_cipher(rsp_ch.cipher_letter, rsp_ch.last);
            hold_left = draw_gap();
         end else if (hold_left != 0) begin
            hold_left--;
         end else if ($urandom_range(0, 19) == 0) begin
            hold_left = draw_gap();
         end
         rsp_ch.ready <= (hold_left == 0);
      end
   end

   task automatic queue_plain(input pfe_pkg::action_type act, input int l);
      plain_item_type item;
      item.act = act;
      item.letter = 5'(l);
      plain_backlog.insert(plain_backlog.size(), item);
   endtask

   task automatic queue_text_cells(input int p, input int q);
      queue_plain(pfe_pkg::ACT_TEXT, key_square[p]);
      queue_plain(pfe_pkg::ACT_TEXT, key_square[q]);
   endtask

   function automatic pfe_pkg::letter_type text_spelling(input pfe_pkg::letter_type l);
      return (l == pfe_pkg::LetterV && $urandom_range(0, 1) == 1) ? pfe_pkg::LetterW : l;
   endfunction

   task automatic queue_noise(input bit pair_is_open);
      case ($urandom_range(0, pair_is_open ? 2 : 3))
         0: queue_plain(pfe_pkg::ACT_KEY, $urandom_range(0, 31));
         1: queue_plain(pfe_pkg::ACT_FINISH, $urandom_range(0, 31));
         2: queue_plain(pfe_pkg::ACT_TEXT, $urandom_range(26, 31));
         default: queue_plain(pfe_pkg::ACT_END, $urandom_range(0, 31));
      endcase
   endtask

   task automatic wait_drained(input bit results_too);
      do @(negedge clock);
      while (plain_backlog.size() != 0 || req_ch.valid ||
             (results_too && cipher_due.size() != 0));
   endtask

   initial begin
      int text_sent;
      int p, q, form;
      bit paused;
      text_sent = 0;
      paused = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.action = pfe_pkg::ACT_KEY;
      req_ch.letter = '0;
      rsp_ch.ready = 1'b0;

      queue_plain(pfe_pkg::ACT_TEXT, 3);
      queue_plain(pfe_pkg::ACT_END, 0);
      queue_plain(pfe_pkg::ACT_KEY, 25);
      queue_plain(pfe_pkg::ACT_KEY, pfe_pkg::LetterW);
      queue_plain(pfe_pkg::ACT_KEY, pfe_pkg::LetterV);
      queue_plain(pfe_pkg::ACT_KEY, 0);
      queue_plain(pfe_pkg::ACT_KEY, 31);
      queue_plain(pfe_pkg::ACT_KEY, 0);
      repeat ($urandom_range(0, 10)) queue_plain(pfe_pkg::ACT_KEY, $urandom_range(0, 31));
      queue_plain(pfe_pkg::ACT_FINISH, 0);
      queue_plain(pfe_pkg::ACT_FINISH, 31);
      queue_plain(pfe_pkg::ACT_KEY, 5);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait_drained(1'b1);

      queue_text_cells(0, 1);
      queue_text_cells(3, 4);
      queue_text_cells(0, 20);
      queue_text_cells(2, 12);
      queue_text_cells(0, 6);
      queue_text_cells(12, 12);
      queue_plain(pfe_pkg::ACT_TEXT, pfe_pkg::LetterW);
      queue_plain(pfe_pkg::ACT_TEXT, 0);
      queue_plain(pfe_pkg::ACT_TEXT, 25);
      queue_plain(pfe_pkg::ACT_TEXT, 31);
      queue_plain(pfe_pkg::ACT_TEXT, pfe_pkg::LetterV);
      queue_plain(pfe_pkg::ACT_TEXT, key_square[18]);
      queue_plain(pfe_pkg::ACT_END, 0);
      queue_plain(pfe_pkg::ACT_END, 0);
      queue_plain(pfe_pkg::ACT_TEXT, 26);

      while (text_sent < 600) begin
         if (text_sent >= 300 && !paused) begin
            paused = 1'b1;
            wait_drained(1'b1);
         end
         if ($urandom_range(0, 99) < 12) begin
            queue_noise(1'b0);
         end else begin
            p = $urandom_range(0, pfe_pkg::Cells - 1);
            form = $urandom_range(0, 3);
            case (form)
               0: q = (p / pfe_pkg::Side) * pfe_pkg::Side
                      + $urandom_range(0, pfe_pkg::Side - 1);
               1: q = $urandom_range(0, pfe_pkg::Side - 1) * pfe_pkg::Side
                      + p % pfe_pkg::Side;
               2: q = $urandom_range(0, pfe_pkg::Cells - 1);
               default: q = p;
            endcase
            queue_plain(pfe_pkg::ACT_TEXT, text_spelling(key_square[p]));
            if ($urandom_range(0, 9) == 0) queue_noise(1'b1);
            if ($urandom_range(0, 5) == 0) begin
               queue_plain(pfe_pkg::ACT_END, $urandom_range(0, 31));
            end else begin
               queue_plain(pfe_pkg::ACT_TEXT, text_spelling(key_square[q]));
            end
            text_sent += 2;
         end
      end

      wait_drained(1'b1);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: playfair_cipher_encoder_core.f
+incdir+src
src/pfe_pkg.sv
src/pfe_req_if.sv
src/pfe_rsp_if.sv
src/pfe_ram.sv
src/playfair_cipher_encoder_core.sv
src/pfe_checker.sv
test/tb.sv
